FILE: src/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA modular exponentiation package
// Register indexes and operation codes for the modular exponentiation core.
// ----------------------------------------------------------------------------
package rme_pkg;

   // Width of the external data fields and of the register write port.
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned INDEX_W = 2;

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [INDEX_W-1:0] index_type;

   // Register indexes on the configuration channel.
   localparam index_type REG_MODULUS     = 2'd0;
   localparam index_type REG_PUBLIC_EXP  = 2'd1;
   localparam index_type REG_PRIVATE_EXP = 2'd2;

   // Operation select carried in tuser.
   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

endpackage

FILE: src/rsa_modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA modular exponentiation core
// Computes value^exponent mod modulus with one shared modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
// The csr_ channel writes the modulus (index 0), the public exponent (index 1)
// and the private exponent (index 2); other indexes are ignored. It is always
// ready and is meant to be written only while the core is idle.
// The req_ channel takes one beat per operation: tuser selects encrypt (public
// exponent) or decrypt (private exponent) and tdata carries the value. The
// rsp_ channel returns one beat per request with value^exponent mod modulus.
// Datapath: every modular product runs through one shared shift-and-add unit
// that handles one multiplier bit per cycle. The value is first reduced by
// the same unit; then each of the WORD_BITS exponent bits costs one square
// and, when the bit is set, one more product. The result is registered in
// the output register. A zero modulus answers 0 without the shared unit.
// req_tready is high only while the core is idle. A finished result waits in
// a holding state until the output register is free, so a stalled receiver
// holds back the next request but never loses a result.
// Reset loads modulus 1 and both exponents 0, and empties the output register.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rme_pkg::data_type  req_tdata,   // [31:0] value
   input  logic               req_tuser,   // [0] func
   // Result channel.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output rme_pkg::data_type  rsp_tdata,   // [31:0] result
   // Configuration write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  rme_pkg::index_type csr_index,
   input  rme_pkg::data_type  csr_wdata
);
   import rme_pkg::*;

   localparam int unsigned CNT_W = $clog2(WORD_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
   localparam logic [2:0] ST_RED  = 3'd1;  // reducing the value modulo n
   localparam logic [2:0] ST_SQR  = 3'd2;  // squaring the running power
   localparam logic [2:0] ST_MUL  = 3'd3;  // multiplying by the reduced base
   localparam logic [2:0] ST_FIN  = 3'd4;  // waiting for the output register

   typedef logic [WORD_BITS-1:0] word_type;

   // (x + y) mod m for x, y below m, without growing past the word.
   function automatic word_type add_mod(input word_type x, input word_type y,
                                        input word_type m);
      word_type room;
      room = m - y;
      if (x >= room) begin
         return x - room;
      end
      return x + y;
   endfunction

   logic [2:0]       state_ff, state_in;
   word_type         mod_ff, pub_ff, priv_ff;
   word_type         acc_ff, acc_in;     // product accumulator
   word_type         x_ff, x_in;         // multiplicand
   word_type         y_ff, y_in;         // multiplier, consumed from the top
   logic [CNT_W-1:0] mcnt_ff, mcnt_in;   // multiplier bit count
   word_type         exp_ff, exp_in;     // exponent, consumed from the top
   logic [CNT_W-1:0] ecnt_ff, ecnt_in;   // exponent bit count
   word_type         pw_ff, pw_in;       // running power
   word_type         base_ff, base_in;   // value mod n
   logic             rsp_valid_ff, rsp_valid_in;
   data_type         rsp_data_ff, rsp_data_in;

   word_type         one_mod;
   word_type         dbl;
   word_type         step;
   logic             mul_done;
   logic             req_fire;
   logic             out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // One mod n, which is zero for a modulus of one.
   assign one_mod = (mod_ff == word_type'(1)) ? '0 : word_type'(1);

   // Shared unit: one shift-and-add step of a modular product.
   assign dbl      = add_mod(acc_ff, acc_ff, mod_ff);
   assign step     = y_ff[WORD_BITS-1] ? add_mod(dbl, x_ff, mod_ff) : dbl;
   assign mul_done = (mcnt_ff == CNT_LAST);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mcnt_in      = mcnt_ff;
      exp_in       = exp_ff;
      ecnt_in      = ecnt_ff;
      pw_in        = pw_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (state_ff == ST_RED || state_ff == ST_SQR || state_ff == ST_MUL) begin
         acc_in  = step;
         y_in    = y_ff << 1;
         mcnt_in = mcnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               exp_in  = (req_tuser == FUNC_DECRYPT) ? priv_ff : pub_ff;
               ecnt_in = '0;
               mcnt_in = '0;
               acc_in  = '0;
               if (mod_ff == '0) begin
                  pw_in    = '0;
                  state_in = ST_FIN;
               end else begin
                  // Reduce the value: one_mod times value, mod n.
                  x_in     = one_mod;
                  y_in     = word_type'(req_tdata);
                  state_in = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (mul_done) begin
               base_in  = step;
               pw_in    = one_mod;
               x_in     = one_mod;
               y_in     = one_mod;
               acc_in   = '0;
               mcnt_in  = '0;
               state_in = ST_SQR;
            end
         end
         ST_SQR, ST_MUL: begin
            if (mul_done) begin
               pw_in   = step;
               acc_in  = '0;
               mcnt_in = '0;
               if (state_ff == ST_SQR && exp_ff[WORD_BITS-1]) begin
                  x_in     = step;
                  y_in     = base_ff;
                  state_in = ST_MUL;
               end else if (ecnt_ff == CNT_LAST) begin
                  state_in = ST_FIN;
               end else begin
                  // Move on to the next exponent bit.
                  exp_in   = exp_ff << 1;
                  ecnt_in  = ecnt_ff + CNT_W'(1);
                  x_in     = step;
                  y_in     = step;
                  state_in = ST_SQR;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_W'(pw_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mcnt_ff      <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= word_type'(1);
         pub_ff       <= '0;
         priv_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         mcnt_ff      <= mcnt_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_MODULUS:     mod_ff  <= word_type'(csr_wdata);
               REG_PUBLIC_EXP:  pub_ff  <= word_type'(csr_wdata);
               REG_PRIVATE_EXP: priv_ff <= word_type'(csr_wdata);
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      exp_ff      <= exp_in;
      pw_ff       <= pw_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted request always starts work.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_RED || state_ff == ST_FIN))
      else $error("request accepted but sequencer did not start");

   // The product bit counter is parked whenever the shared unit is not in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FIN) |-> (mcnt_ff == '0))
      else $error("product counter running outside a product");

   // A result is loaded only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FIN))
      else $error("result left the holding state while output was stalled");

endmodule

FILE: dv/rsa_modexp_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA modular exponentiation result monitor
// Watches the register, request and result channels of the core, predicts
// value^exponent mod modulus for each request and compares every result beat.
// ----------------------------------------------------------------------------
module rsa_modexp_monitor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  rme_pkg::data_type  req_tdata,
   input  logic               req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rme_pkg::data_type  rsp_tdata,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  rme_pkg::index_type csr_index,
   input  rme_pkg::data_type  csr_wdata,
   output int                 failures,
   output int                 pending
);
   import rme_pkg::*;

   data_type modulus_word;
   data_type encrypt_exponent;
   data_type decrypt_exponent;
   data_type predicted_powers[$];
   int       mismatch_count = 0;
   int       waiting_count  = 0;

   assign failures = mismatch_count;
   assign pending  = waiting_count;

   // Right-to-left square-and-multiply on 64-bit products.
   function automatic data_type power_mod(data_type base, data_type exponent, data_type m);
      logic [63:0] wide_m;
      logic [63:0] product_acc;
      logic [63:0] square;
      if (m == '0) begin
         return '0;
      end
      wide_m      = 64'(m);
      product_acc = 64'd1 % wide_m;
      square      = 64'(base) % wide_m;
      for (int i = 0; i < DATA_W; i++) begin
         if (exponent[i]) begin
            product_acc = (product_acc * square) % wide_m;
         end
         square = (square * square) % wide_m;
      end
      return product_acc[DATA_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      data_type expected;
      if (reset) begin
         modulus_word     = 32'd1;
         encrypt_exponent = '0;
         decrypt_exponent = '0;
         predicted_powers.delete();
      end else begin
         // A request sees the registers as they stood before this edge.
         if (req_tvalid && req_tready) begin
            predicted_powers = {predicted_powers, power_mod(req_tdata,
               (req_tuser == FUNC_DECRYPT) ? decrypt_exponent : encrypt_exponent,
               modulus_word)};
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODULUS:     modulus_word     = csr_wdata;
               REG_PUBLIC_EXP:  encrypt_exponent = csr_wdata;
               REG_PRIVATE_EXP: decrypt_exponent = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_powers.size() == 0) begin
               $display("%0t: result beat with none pending: expected nothing, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               expected = predicted_powers.pop_front();
               if (rsp_tdata !== expected) begin
                  $display("%0t: result mismatch: expected %h, actual %h",
                           $time, expected, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
      end
      waiting_count = predicted_powers.size();
   end

endmodule

FILE: dv/rsa_modular_exponentiation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA modular exponentiation core test
// Drives register writes and encrypt/decrypt requests into the core with
// random idle bursts on both channels, while a monitor beside the core
// predicts each result and compares it. Directed cases come first, then
// phases of random key material and random values.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_test;
   import rme_pkg::*;

   // The watchdog allows several times the longest request plus the longest
   // idle bursts between two accepted beats.
   localparam int unsigned WATCHDOG_LIMIT = 10000;
   localparam int unsigned RANDOM_ITEMS   = 256;
   // The tail of the run goes with no idling at all.
   localparam int unsigned CALM_ITEMS     = 40;
   // Quiet cycles after the last result, long enough to catch a stray beat
   // from a zero modulus request.
   localparam int unsigned SETTLE_CYCLES  = 64;
   // Index beyond the register map; the core must ignore writes to it.
   localparam index_type   REG_UNMAPPED   = 2'd3;

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_tvalid = 1'b0;
   logic      req_tready;
   data_type  req_tdata  = '0;
   logic      req_tuser  = FUNC_ENCRYPT;
   logic      rsp_tvalid;
   logic      rsp_tready = 1'b0;
   data_type  rsp_tdata;
   logic      csr_valid  = 1'b0;
   logic      csr_ready;
   index_type csr_index  = REG_MODULUS;
   data_type  csr_wdata  = '0;

   int          failures;
   int          pending;
   // When set, neither side inserts idle bursts.
   bit          idle_free   = 1'b0;
   int unsigned rsp_stall   = 0;
   int unsigned quiet_count = 0;

   always #4 clock = ~clock;

   rsa_modular_exponentiation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value
      .req_tuser  (req_tuser),   // [0] func
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] result
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rsa_modexp_monitor power_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   // Result side back-pressure. A stall starts now and then and holds
   // rsp_tready low until a random down-counter runs out, so that results
   // finish while the receiver is both ready and stalled. A stall in progress
   // is dropped once idling is switched off.
   always @(negedge clock) begin
      if (rsp_stall != 0 && !idle_free) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 15) == 0) begin
         rsp_stall  <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_stall  <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: counts cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count + 1 >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // Writes one register. Entered and left at a falling edge; csr_valid is
   // left high so that a following write keeps it up without a glitch.
   task automatic write_reg(index_type index, data_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Sends one request beat, sometimes after an idle burst with tvalid low.
   // The core is ready only when idle, so tvalid normally waits high for a
   // long while here.
   task automatic send_request(logic func, data_type value);
      int unsigned gap;
      if (!idle_free && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drops tvalid and waits until every predicted result has come back, which
   // leaves the core idle and ready for register writes.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Exponents lean toward the edges: zero, all ones and short ones.
   function automatic data_type pick_exponent();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(1, 255);
         default: return $urandom;
      endcase
   endfunction

   // One random key setting followed by a burst of requests under it.
   task automatic random_phase(int unsigned count);
      data_type modulus_word;
      data_type value;
      logic     func;
      case ($urandom_range(0, 7))
         0:       modulus_word = '0;
         1:       modulus_word = 32'd1;
         2:       modulus_word = '1;
         3:       modulus_word = $urandom_range(2, 65535);
         default: modulus_word = $urandom;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         write_reg(REG_UNMAPPED, $urandom);
      end
      write_reg(REG_MODULUS, modulus_word);
      write_reg(REG_PUBLIC_EXP, pick_exponent());
      write_reg(REG_PRIVATE_EXP, pick_exponent());
      csr_valid <= 1'b0;
      repeat (count) begin
         case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            2, 3:    value = (modulus_word > 1) ? $urandom % modulus_word : $urandom;
            default: value = $urandom;
         endcase
         func = $urandom_range(0, 1) ? FUNC_DECRYPT : FUNC_ENCRYPT;
         send_request(func, value);
      end
      drain();
   endtask

   initial begin
      int unsigned sent;
      int unsigned phase_items;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: modulus one and zero exponents, so every result is 0,
      // including for the largest value.
      @(negedge clock);
      send_request(FUNC_ENCRYPT, '1);
      send_request(FUNC_DECRYPT, '0);
      drain();

      // A zero modulus answers 0 regardless of value or exponent.
      write_reg(REG_MODULUS, '0);
      write_reg(REG_PUBLIC_EXP, 32'd5);
      write_reg(REG_PRIVATE_EXP, 32'd7);
      csr_valid <= 1'b0;
      send_request(FUNC_ENCRYPT, 32'd3);
      send_request(FUNC_DECRYPT, '1);
      drain();

      // Largest modulus with an all-ones exponent and a zero exponent. The
      // all-ones value equals the modulus and reduces to 0; zero raised to
      // the zero exponent must still give 1.
      write_reg(REG_MODULUS, '1);
      write_reg(REG_PUBLIC_EXP, '1);
      write_reg(REG_PRIVATE_EXP, '0);
      csr_valid <= 1'b0;
      send_request(FUNC_ENCRYPT, '1);
      send_request(FUNC_DECRYPT, '0);
      send_request(FUNC_ENCRYPT, 32'hFFFF_FFFE);
      send_request(FUNC_DECRYPT, 32'd12345);
      drain();

      // A small textbook key pair (n = 61 * 53): a round trip of 65, values
      // at and above the modulus, and a write to an unmapped index that must
      // change nothing.
      write_reg(REG_MODULUS, 32'd3233);
      write_reg(REG_PUBLIC_EXP, 32'd17);
      write_reg(REG_PRIVATE_EXP, 32'd2753);
      write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
      csr_valid <= 1'b0;
      send_request(FUNC_ENCRYPT, 32'd65);
      send_request(FUNC_DECRYPT, 32'd2790);
      send_request(FUNC_ENCRYPT, 32'd5000);
      send_request(FUNC_DECRYPT, 32'd3233);
      drain();

      // Power-of-two modulus with exponents one and two; the values straddle
      // the modulus.
      write_reg(REG_MODULUS, 32'h8000_0000);
      write_reg(REG_PUBLIC_EXP, 32'd1);
      write_reg(REG_PRIVATE_EXP, 32'd2);
      csr_valid <= 1'b0;
      send_request(FUNC_ENCRYPT, 32'h8000_0001);
      send_request(FUNC_DECRYPT, 32'h7FFF_FFFF);
      drain();

      // Random phases. Some run without idling; the last stretch always does.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_items = $urandom_range(4, 24);
         if (phase_items > RANDOM_ITEMS - sent) begin
            phase_items = RANDOM_ITEMS - sent;
         end
         idle_free <= (RANDOM_ITEMS - sent <= CALM_ITEMS) || ($urandom_range(0, 4) == 0);
         random_phase(phase_items);
         sent += phase_items;
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: rsa_modular_exponentiation.f
src/rme_pkg.sv
src/rsa_modular_exponentiation.sv
dv/rsa_modexp_monitor.sv
dv/rsa_modular_exponentiation_test.sv
